FILE: rtl/ctf_pkg.sv
`default_nettype none
package ctf_pkg;

    localparam int CordicSteps = 16;
    localparam int StepsRun = (CordicSteps < 24) ? CordicSteps : 24;
    localparam int StepW = 5;

    localparam logic signed [23:0] SatMax = 24'sh7FFFFF;
    localparam logic signed [23:0] SatMin = -24'sh800000;
    localparam logic [22:0] KRate = 23'd4685083;
    localparam logic signed [26:0] HalfPi24 = 27'sd26353589;

    // Configuration register indexes.
    localparam logic [2:0] RegGyroOff = 3'd0;
    localparam logic [2:0] RegAyOff   = 3'd1;
    localparam logic [2:0] RegAzOff   = 3'd2;
    localparam logic [2:0] RegStep    = 3'd3;
    localparam logic [2:0] RegHpGain  = 3'd4;
    localparam logic [2:0] RegLpGain  = 3'd5;

    // One classified sample as it waits in the queue.
    // The CORDIC vector carries headroom for the CORDIC gain on a full-scale input.
    typedef struct packed {
        logic signed [16:0] rate;
        logic signed [34:0] cx;
        logic signed [34:0] cy;
        logic signed [26:0] acc0;
        logic               zero;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE, ST_M1, ST_M2, ST_INT, ST_HP, ST_CORDIC,
        ST_LP1, ST_LP2, ST_LP3, ST_OUT
    } t_state;

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        if (v > 48'sd8388607) return SatMax;
        if (v < -48'sd8388608) return SatMin;
        return v[23:0];
    endfunction

    function automatic logic [26:0] atan_entry(input logic [StepW-1:0] i);
        case (i)
            5'd0: return 27'd13176795;
            5'd1: return 27'd7778716;
            5'd2: return 27'd4110060;
            5'd3: return 27'd2086331;
            5'd4: return 27'd1047214;
            5'd5: return 27'd524117;
            5'd6: return 27'd262123;
            5'd7: return 27'd131069;
            default: return 27'd1 << (5'd24 - i);
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ctf_front.sv
`default_nettype none
module ctf_front import ctf_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_gyro_rate,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic signed [15:0] i_accel_z,
    input  wire logic signed [15:0] i_gyro_off,
    input  wire logic signed [15:0] i_ay_off,
    input  wire logic signed [15:0] i_az_off,
    output logic                    o_job_valid,
    input  wire logic               i_job_ready,
    output t_job                    o_job
);
    // Two-entry queue between front and back.
    t_job r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic r_wp, r_rp;
    t_job w_job;
    logic signed [16:0] w_ay, w_az, w_y;
    logic w_push, w_pop;

    // Offset removal and quadrant fold ahead of the CORDIC.
    always_comb begin
        w_ay = 17'(i_accel_y) - 17'(i_ay_off);
        w_az = 17'(i_accel_z) - 17'(i_az_off);
        w_y  = -w_az;
        w_job.rate = 17'(i_gyro_rate) - 17'(i_gyro_off);
        w_job.zero = (w_ay == 17'sd0) && (w_az == 17'sd0);
        w_job.cx = 35'(w_ay) <<< 16;
        w_job.cy = 35'(w_y) <<< 16;
        w_job.acc0 = '0;
        if (w_ay < 0) begin
            if (w_y >= 0) begin
                w_job.cx = 35'(w_y) <<< 16;
                w_job.cy = -(35'(w_ay) <<< 16);
                w_job.acc0 = HalfPi24;
            end else begin
                w_job.cx = -(35'(w_y) <<< 16);
                w_job.cy = 35'(w_ay) <<< 16;
                w_job.acc0 = -HalfPi24;
            end
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_job_valid && i_job_ready;
    assign n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);

    // Queue pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_job;
    end
endmodule
`default_nettype wire

FILE: rtl/ctf_back.sv
`default_nettype none
module ctf_back import ctf_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_job_valid,
    output logic                    o_job_ready,
    input  t_job                    i_job,
    input  wire logic [15:0]        i_time_step,
    input  wire logic [15:0]        i_hp_gain,
    input  wire logic [15:0]        i_lp_gain,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [23:0]      o_gyro_angle_filtered,
    output logic signed [23:0]      o_accel_angle_filtered,
    output logic signed [23:0]      o_fused_angle
);
    t_state r_state, n_state;
    t_job r_job;
    logic signed [23:0] r_int, r_lp, r_hpo, r_hpi;
    logic signed [63:0] r_prod;
    logic signed [47:0] r_prod2;
    logic signed [34:0] r_x, r_y;
    logic signed [26:0] r_acc;
    logic [StepW-1:0] r_i;
    logic signed [23:0] r_a;
    logic r_ov;
    logic signed [23:0] r_og, r_oa, r_of;

    logic w_take, w_last;
    logic signed [34:0] w_dx, w_dy;
    logic signed [47:0] w_d, w_hpsum, w_intsum, w_lpsum;
    logic signed [26:0] w_accr;

    assign w_take = (r_state == ST_IDLE) && i_job_valid;
    assign o_job_ready = (r_state == ST_IDLE);
    assign w_last = (r_i == StepW'(StepsRun - 1));
    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_d = 48'((r_prod + 64'sd2147483648) >>> 32);
    assign w_intsum = 48'(r_int) + w_d;
    assign w_hpsum = 48'(r_hpo) + 48'(r_int) - 48'(r_hpi);
    assign w_accr = (r_acc + 27'sd128) >>> 8;
    assign w_lpsum = 48'((r_prod + 64'(r_prod2) + 64'sd32768) >>> 16);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_take) n_state = ST_M1;
            ST_M1:     n_state = ST_M2;
            ST_M2:     n_state = ST_INT;
            ST_INT:    n_state = ST_HP;
            ST_HP:     n_state = ST_CORDIC;
            ST_CORDIC: if (w_last) n_state = ST_LP1;
            ST_LP1:    n_state = ST_LP2;
            ST_LP2:    n_state = ST_LP3;
            ST_LP3:    n_state = ST_OUT;
            ST_OUT:    if (!r_ov || i_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control registers and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_int <= '0;
            r_lp <= '0;
            r_hpo <= '0;
            r_hpi <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_OUT) && (!r_ov || i_ready)) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                ST_INT: r_int <= sat24(w_intsum);
                ST_LP1: begin
                    r_hpo <= sat24(48'((r_prod + 64'sd32768) >>> 16));
                    r_hpi <= r_int;
                end
                ST_LP3: r_lp <= sat24(w_lpsum);
                default: ;
            endcase
        end
    end

    // Datapath: one multiply per step, two in the second low-pass step; shared CORDIC iteration.
    // The high-pass product is formed after the integrator update and is
    // held through the CORDIC until the filter state takes it.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_job <= i_job;
                r_x <= i_job.cx;
                r_y <= i_job.cy;
                r_acc <= i_job.acc0;
                r_i <= '0;
            end
            ST_M1: r_prod <= 64'(r_job.rate) * 64'($signed({1'b0, i_time_step}));
            ST_M2: r_prod <= 64'($signed(r_prod[33:0])) * 64'($signed({1'b0, KRate}));
            ST_HP: r_prod <= 64'($signed({1'b0, i_hp_gain})) * 64'(w_hpsum);
            ST_CORDIC: begin
                if (r_y > 0) begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_acc <= r_acc + $signed(atan_entry(r_i));
                end else begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_acc <= r_acc - $signed(atan_entry(r_i));
                end
                r_i <= r_i + StepW'(1);
            end
            ST_LP1: r_a <= r_job.zero ? 24'sd0 : w_accr[23:0];
            ST_LP2: begin
                r_prod <= 64'($signed({1'b0, i_lp_gain})) * 64'(r_a);
                r_prod2 <= (48'sd65536 - 48'($signed({1'b0, i_lp_gain}))) * 48'(r_lp);
            end
            ST_OUT: if (!r_ov || i_ready) begin
                r_og <= r_hpo;
                r_oa <= r_lp;
                r_of <= sat24(48'(r_hpo) + 48'(r_lp));
            end
            default: ;
        endcase
    end

    assign o_valid = r_ov;
    assign o_gyro_angle_filtered = r_og;
    assign o_accel_angle_filtered = r_oa;
    assign o_fused_angle = r_of;
endmodule
`default_nettype wire

FILE: rtl/complementary_tilt_filter.sv
`default_nettype none
// Complementary tilt filter for one IMU axis.
// Input channel (i_valid/i_ready): one beat carries a gyro X rate and
// accelerometer Y and Z samples. Output channel (o_valid/o_ready): one beat
// carries the high-passed gyro angle, the low-passed accelerometer angle
// and their saturated sum, all in 2^-16 rad.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_addr;
// indexes beyond the register list are ignored. Write only when idle.
// A front stage removes offsets and folds the accel vector into the right
// half plane; a two-entry queue hands the job to a back sequencer.
// For each beat the back sequencer steps through the shared multiplier
// steps and the one-step-per-cycle CORDIC (16 CORDIC steps by default),
// and it takes a new job from the queue only when it is idle.
// The output register holds a finished result while the receiver stalls;
// the queue keeps accepting until two jobs wait.
// Synchronous reset restores the register defaults and clears all filter
// state.
module complementary_tilt_filter import ctf_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_gyro_rate,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic signed [15:0] i_accel_z,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [23:0]      o_gyro_angle_filtered,
    output logic signed [23:0]      o_accel_angle_filtered,
    output logic signed [23:0]      o_fused_angle,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_addr,
    input  wire logic [15:0]        i_cfg_data
);
    logic signed [15:0] r_gyro_off, r_ay_off, r_az_off;
    logic [15:0] r_step, r_hp_gain, r_lp_gain;
    logic w_job_valid, w_job_ready;
    t_job w_job;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_off <= -16'sd8;
            r_ay_off <= 16'sd13;
            r_az_off <= 16'sd58;
            r_step <= 16'd655;
            r_hp_gain <= 16'd65208;
            r_lp_gain <= 16'd327;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                RegGyroOff: r_gyro_off <= i_cfg_data;
                RegAyOff:   r_ay_off <= i_cfg_data;
                RegAzOff:   r_az_off <= i_cfg_data;
                RegStep:    r_step <= i_cfg_data;
                RegHpGain:  r_hp_gain <= i_cfg_data;
                RegLpGain:  r_lp_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ctf_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_gyro_rate, .i_accel_y, .i_accel_z,
        .i_gyro_off(r_gyro_off), .i_ay_off(r_ay_off), .i_az_off(r_az_off),
        .o_job_valid(w_job_valid), .i_job_ready(w_job_ready), .o_job(w_job)
    );

    ctf_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(w_job_valid), .o_job_ready(w_job_ready), .i_job(w_job),
        .i_time_step(r_step), .i_hp_gain(r_hp_gain), .i_lp_gain(r_lp_gain),
        .o_valid, .i_ready,
        .o_gyro_angle_filtered, .o_accel_angle_filtered, .o_fused_angle
    );
endmodule
`default_nettype wire

FILE: rtl/ctf_checker.sv
`default_nettype none
module ctf_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic               o_ready,
    input wire logic signed [23:0] o_gyro_angle_filtered,
    input wire logic signed [23:0] o_accel_angle_filtered,
    input wire logic signed [23:0] o_fused_angle
);
    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_fused_angle))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");

    // Reset leaves the input side open.
    a_open: assert property (@(posedge i_clk) !i_rst_n |=> o_ready)
        else $error("not ready after reset");

    // Two non-negative parts never give a negative fused angle.
    a_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_gyro_angle_filtered[23] && !o_accel_angle_filtered[23]
        |-> !o_fused_angle[23])
        else $error("fused angle sign wrong");
endmodule

bind complementary_tilt_filter ctf_checker u_checker (.*);
`default_nettype wire
